>>> src/tsem_pkg.sv
// types and constants shared by the timestamp event merger
package tsem_pkg;

  localparam int SRC_W     = 2;
  localparam int TIME_W    = 32;
  localparam int SIZE_W    = 2;
  localparam int BYTES_W   = 24;
  localparam int ENTRY_W   = TIME_W + SIZE_W + BYTES_W;
  localparam int DATA_W    = 64;
  localparam int IN_USER_W = 1 + SRC_W;

  localparam logic OP_RENDER = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_RENDER,
    CMD_DROP
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_FETCH,
    BE_SCAN,
    BE_EMIT
  } be_state_t;

  // time in the low bits, then size, then bytes
  typedef struct packed {
    logic [BYTES_W-1:0] ev_bytes;
    logic [SIZE_W-1:0]  ev_size;
    logic [TIME_W-1:0]  ev_time;
  } entry_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [SRC_W-1:0] source;
    entry_t           entry;
  } cmd_t;

endpackage

>>> src/timestamp_event_merger_top.sv
// top level of the timestamp event merger
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  in_*     | input     | tuser: op, source; tdata: time, size, bytes
//  out_*    | output    | tuser: source; tdata: time, size, bytes; tlast
//
//  a load item is taken by the back end while idle, queued behind a two item buffer
//  a render emits its items one at a time, each through a store read step, a scan
//  of one source head per cycle and an emit step; an empty render leaves it idle
//  reset clears fill counts, read positions, the queue and the output valid flag;
//  store contents are not cleared
//  a stalled output holds the back end in its emit step; input stalls once the
//  queue holds two items
module timestamp_event_merger_top #(
  parameter int NUM_SOURCES       = 4,
  parameter int EVENTS_PER_SOURCE = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tsem_pkg::DATA_W-1:0]    in_tdata,   // event_time, event_size, event_bytes, zeros
  input  logic [tsem_pkg::IN_USER_W-1:0] in_tuser,   // op, source
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tsem_pkg::DATA_W-1:0]    out_tdata,  // out_time, out_size, out_bytes, zeros
  output logic [tsem_pkg::SRC_W-1:0]     out_tuser,  // out_source
  output logic                           out_tlast
);
  import tsem_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  tsem_front #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  tsem_back #(
    .NUM_SOURCES       (NUM_SOURCES),
    .EVENTS_PER_SOURCE (EVENTS_PER_SOURCE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_out_from_render: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!cmd_ready))
    else $error("output item raised outside a render");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && cmd_ready && (cmd.kind != CMD_RENDER) && !out_tvalid) |=> !out_tvalid)
    else $error("load or dropped item produced an output item");

  a_stall_needs_queue: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> cmd_valid)
    else $error("input stalled with an empty queue");

endmodule

>>> src/tsem_ram.sv
// generic single write port ram with registered read
module tsem_ram #(
  parameter int WIDTH = 58,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/tsem_front.sv
// input side: accepts items, classifies them and queues them for the back end
module tsem_front #(
  parameter int NUM_SOURCES = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tsem_pkg::DATA_W-1:0]    in_tdata,
  input  logic [tsem_pkg::IN_USER_W-1:0] in_tuser,
  output logic                           cmd_valid,
  input  logic                           cmd_ready,
  output tsem_pkg::cmd_t                 cmd
);
  import tsem_pkg::*;

  cmd_t             q_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  cmd_t             in_cmd;
  logic [SRC_W-1:0] in_src;
  logic             push, pop;

  always_comb begin
    in_src        = in_tuser[SRC_W:1];
    in_cmd.source = in_src;
    in_cmd.entry  = in_tdata[ENTRY_W-1:0];
    if (in_tuser[0] == OP_RENDER) begin
      in_cmd.kind = CMD_RENDER;
    end else if ({{(32-SRC_W){1'b0}}, in_src} >= 32'(NUM_SOURCES)) begin
      in_cmd.kind = CMD_DROP;
    end else begin
      in_cmd.kind = CMD_LOAD;
    end
  end

  assign in_tready = (count_r != 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_tvalid & in_tready;
  assign pop       = cmd_valid & cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

>>> src/tsem_back.sv
// back end: per-source stores, loads and the merge sequencer with output register
module tsem_back #(
  parameter int NUM_SOURCES       = 4,
  parameter int EVENTS_PER_SOURCE = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  tsem_pkg::cmd_t               cmd,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [tsem_pkg::DATA_W-1:0]  out_tdata,
  output logic [tsem_pkg::SRC_W-1:0]   out_tuser,
  output logic                         out_tlast
);
  import tsem_pkg::*;

  localparam int SW = $clog2(NUM_SOURCES);
  localparam int FW = $clog2(EVENTS_PER_SOURCE + 1);
  localparam int AW = (EVENTS_PER_SOURCE > 1) ? $clog2(EVENTS_PER_SOURCE) : 1;
  localparam int TW = $clog2(NUM_SOURCES * EVENTS_PER_SOURCE + 1);

  be_state_t        state_r, state_nxt;
  logic [FW-1:0]    fill_r [NUM_SOURCES];
  logic [FW-1:0]    fill_nxt [NUM_SOURCES];
  logic [FW-1:0]    rp_r [NUM_SOURCES];
  logic [FW-1:0]    rp_nxt [NUM_SOURCES];
  logic [TW-1:0]    remain_r, remain_nxt;
  logic [SW-1:0]    scan_r, scan_nxt;
  logic             found_r, found_nxt;
  logic [SW-1:0]    best_src_r, best_src_nxt;
  entry_t           best_r, best_nxt;
  logic             out_valid_r, out_valid_nxt;
  entry_t           out_entry_r, out_entry_nxt;
  logic [SRC_W-1:0] out_src_r, out_src_nxt;
  logic             out_last_r, out_last_nxt;

  entry_t           rd_entry [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] pend, room, we;
  logic             load_go;
  logic [SW-1:0]    ld_src;
  entry_t           cand;

  assign ld_src = SW'(cmd.source);

  for (genvar g = 0; g < NUM_SOURCES; g++) begin : g_src
    assign pend[g] = (rp_r[g] < fill_r[g]);
    assign room[g] = (fill_r[g] < FW'(EVENTS_PER_SOURCE));
    assign we[g]   = load_go && (ld_src == SW'(g)) && room[g];

    tsem_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (EVENTS_PER_SOURCE)
    ) u_store (
      .clk   (clk),
      .we    (we[g]),
      .waddr (fill_r[g][AW-1:0]),
      .wdata (cmd.entry),
      .raddr (rp_r[g][AW-1:0]),
      .rdata (rd_entry[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    rp_nxt        = rp_r;
    remain_nxt    = remain_r;
    scan_nxt      = scan_r;
    found_nxt     = found_r;
    best_src_nxt  = best_src_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_entry_nxt = out_entry_r;
    out_src_nxt   = out_src_r;
    out_last_nxt  = out_last_r;
    cmd_ready     = 1'b0;
    load_go       = 1'b0;
    cand          = rd_entry[scan_r];
    case (state_r)
      BE_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_LOAD: begin
              load_go = 1'b1;
              if (room[ld_src]) begin
                remain_nxt = remain_r + TW'(1);
                for (int s = 0; s < NUM_SOURCES; s++) begin
                  if (ld_src == SW'(s)) begin
                    fill_nxt[s] = fill_r[s] + FW'(1);
                  end
                end
              end
            end
            CMD_RENDER: begin
              if (remain_r != '0) begin
                state_nxt = BE_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      BE_FETCH: begin
        // store read data settles on the new read positions
        scan_nxt  = '0;
        found_nxt = 1'b0;
        state_nxt = BE_SCAN;
      end
      BE_SCAN: begin
        if (pend[scan_r] && (!found_r || (cand.ev_time < best_r.ev_time))) begin
          found_nxt    = 1'b1;
          best_src_nxt = scan_r;
          best_nxt     = cand;
        end
        if (scan_r == SW'(NUM_SOURCES - 1)) begin
          state_nxt = BE_EMIT;
        end else begin
          scan_nxt = scan_r + SW'(1);
        end
      end
      BE_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_entry_nxt = best_r;
          out_src_nxt   = SRC_W'(best_src_r);
          out_last_nxt  = (remain_r == TW'(1));
          remain_nxt    = remain_r - TW'(1);
          if (remain_r == TW'(1)) begin
            state_nxt = BE_IDLE;
            for (int s = 0; s < NUM_SOURCES; s++) begin
              fill_nxt[s] = '0;
              rp_nxt[s]   = '0;
            end
          end else begin
            state_nxt = BE_FETCH;
            for (int s = 0; s < NUM_SOURCES; s++) begin
              if (best_src_r == SW'(s)) begin
                rp_nxt[s] = rp_r[s] + FW'(1);
              end
            end
          end
        end
      end
      default: state_nxt = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BE_IDLE;
      remain_r    <= '0;
      scan_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < NUM_SOURCES; s++) begin
        fill_r[s] <= '0;
        rp_r[s]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      remain_r    <= remain_nxt;
      scan_r      <= scan_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
      rp_r        <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_src_r  <= best_src_nxt;
    best_r      <= best_nxt;
    out_entry_r <= out_entry_nxt;
    out_src_r   <= out_src_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(DATA_W - ENTRY_W){1'b0}}, out_entry_r};
  assign out_tuser  = out_src_r;
  assign out_tlast  = out_last_r;

endmodule

>>> tb/timestamp_event_merger_top_tb.sv
// self-checking testbench for the timestamp event merger: loads, renders and merge order
module timestamp_event_merger_top_tb;
  import tsem_pkg::*;

  localparam int NSRC       = 4;
  localparam int DEPTH      = 16;
  localparam int ITEM_GOAL  = 420;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL       = 4 * (NSRC + 2) + 16;
  localparam logic OP_LOAD  = 1'b0;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [DATA_W-1:0]    in_tdata;
  logic [IN_USER_W-1:0] in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [DATA_W-1:0]    out_tdata;
  logic [SRC_W-1:0]     out_tuser;
  logic                 out_tlast;

  bit tx_calm;
  bit rx_calm;
  int items_taken;

  typedef struct {
    logic [TIME_W-1:0]  ev_time;
    logic [SIZE_W-1:0]  ev_size;
    logic [BYTES_W-1:0] ev_bytes;
    logic [SRC_W-1:0]   ev_src;
    logic               ev_last;
  } merged_ev_t;

  class merge_scoreboard;
    entry_t      store [NSRC][DEPTH];
    int unsigned fill [NSRC];
    merged_ev_t  pending [$];
    int          errors;
    int          seen;

    task report(string field, logic [31:0] got, logic [31:0] want);
      $display("result %0d %0s: got %h expected %h", seen, field, got, want);
      errors++;
    endtask

    // returns 0 for a load that the block drops
    function bit note_input(logic op, logic [SRC_W-1:0] src, entry_t e);
      int unsigned rd [NSRC];
      bit          found;
      int          best;
      int          n;
      int          s;
      merged_ev_t  ev;
      if (op != OP_RENDER) begin
        if (src >= NSRC || fill[src] >= DEPTH) return 0;
        store[src][fill[src]] = e;
        fill[src]++;
        return 1;
      end
      foreach (rd[i]) rd[i] = 0;
      n = 0;
      do begin
        found = 0;
        best  = 0;
        for (s = 0; s < NSRC; s++)
          if (rd[s] < fill[s] &&
              (!found || store[s][rd[s]].ev_time < store[best][rd[best]].ev_time)) begin
            found = 1;
            best  = s;
          end
        if (found) begin
          ev.ev_time  = store[best][rd[best]].ev_time;
          ev.ev_size  = store[best][rd[best]].ev_size;
          ev.ev_bytes = store[best][rd[best]].ev_bytes;
          ev.ev_src   = best[SRC_W-1:0];
          ev.ev_last  = 1'b0;
          pending.push_back(ev);
          rd[best]++;
          n++;
        end
      end while (found);
      if (n > 0) pending[pending.size()-1].ev_last = 1'b1;
      foreach (fill[i]) fill[i] = 0;
      return 1;
    endfunction

    task check_result(logic [DATA_W-1:0] tdata, logic [SRC_W-1:0] tuser, logic tlast);
      entry_t     got;
      merged_ev_t want;
      got = tdata[ENTRY_W-1:0];
      if (pending.size() == 0) begin
        report("no item expected, time", got.ev_time, '0);
      end else begin
        want = pending.pop_front();
        if (got.ev_time !== want.ev_time) report("time", got.ev_time, want.ev_time);
        if (got.ev_size !== want.ev_size)
          report("size", 32'(got.ev_size), 32'(want.ev_size));
        if (got.ev_bytes !== want.ev_bytes)
          report("bytes", 32'(got.ev_bytes), 32'(want.ev_bytes));
        if (tuser !== want.ev_src) report("source", 32'(tuser), 32'(want.ev_src));
        if (tlast !== want.ev_last) report("last", 32'(tlast), 32'(want.ev_last));
      end
      seen++;
    endtask
  endclass

  merge_scoreboard sb = new();

  timestamp_event_merger_top #(
    .NUM_SOURCES       (NSRC),
    .EVENTS_PER_SOURCE (DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  task automatic send_item(logic op, logic [SRC_W-1:0] src, logic [TIME_W-1:0] t,
                           logic [SIZE_W-1:0] sz, logic [BYTES_W-1:0] by);
    int     gap;
    entry_t e;
    gap        = tx_calm ? 0 : $urandom_range(0, 10);
    e.ev_time  = t;
    e.ev_size  = sz;
    e.ev_bytes = by;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DATA_W'(e);
    in_tuser  <= {src, op};
    do @(posedge clk); while (!in_tready);
    void'(sb.note_input(op, src, e));
    items_taken++;
  endtask

  // result side
  initial begin
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata, out_tuser, out_tlast);
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int kind;
    int tmode;
    int n;
    int hot;
    logic [SRC_W-1:0]  src;
    logic [TIME_W-1:0] t;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty render
    send_item(OP_RENDER, 2'd0, '0, '0, '0);
    // extreme times, sizes and bytes, ties across sources
    send_item(OP_LOAD, 2'd0, 32'hFFFF_FFFF, 2'd3, 24'hFF_FFFF);
    send_item(OP_LOAD, 2'd1, 32'h0000_0000, 2'd0, 24'h00_0000);
    send_item(OP_LOAD, 2'd2, 32'd5, 2'd1, 24'h12_3456);
    send_item(OP_LOAD, 2'd3, 32'd5, 2'd2, 24'hAB_CDEF);
    send_item(OP_LOAD, 2'd1, 32'd5, 2'd1, 24'h00_F090);
    send_item(OP_RENDER, 2'd3, 32'hFFFF_FFFF, 2'd3, 24'hFF_FFFF);
    // one store past full
    for (int i = 0; i <= DEPTH; i++)
      send_item(OP_LOAD, 2'd2, $urandom_range(0, 40), SIZE_W'($urandom_range(0, 3)),
                BYTES_W'($urandom_range(0, 24'hFF_FFFF)));
    send_item(OP_RENDER, 2'd1, $urandom, SIZE_W'($urandom), BYTES_W'($urandom));

    while (items_taken < ITEM_GOAL) begin
      kind    = $urandom_range(0, 9);
      tmode   = $urandom_range(0, 2);
      hot     = $urandom_range(0, NSRC - 1);
      tx_calm = ($urandom_range(0, 3) == 0);
      n = (kind == 0) ? 0 : (kind <= 2) ? $urandom_range(40, 72) : $urandom_range(1, 24);
      for (int i = 0; i < n; i++) begin
        src = (kind <= 2 && $urandom_range(0, 1)) ? SRC_W'(hot)
                                                   : SRC_W'($urandom_range(0, NSRC - 1));
        case (tmode)
          0: t = $urandom_range(0, 15);
          1: t = $urandom;
          default: t = {28'hFFF_FFFF, 4'($urandom_range(0, 15))};
        endcase
        send_item(OP_LOAD, src, t, SIZE_W'($urandom_range(0, 3)),
                  BYTES_W'($urandom_range(0, 24'hFF_FFFF)));
      end
      send_item(OP_RENDER, SRC_W'($urandom), $urandom, SIZE_W'($urandom),
                BYTES_W'($urandom));
    end
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
